// File: sv/grid_cluster_percolation_core_macros.svh
// Assertion helpers for the percolation core checker
`ifndef GRID_CLUSTER_PERCOLATION_CORE_MACROS_SVH
`define GRID_CLUSTER_PERCOLATION_CORE_MACROS_SVH

// check a property on every clock edge outside reset
`define GCP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define GCP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: sv/gcp_pkg.sv
package gcp_pkg;
   localparam int MaxSide   = 64;
   localparam int CellCount = MaxSide * MaxSide;
   localparam int AddrW     = $clog2(CellCount);
   localparam int SideW     = $clog2(MaxSide + 1);
   localparam int CoordW    = $clog2(MaxSide);
   localparam int SpW       = AddrW + 1;

   localparam logic [6:0] SideReset = 7'd64;

   typedef logic [AddrW-1:0] addr_type;

   // walk engine status
   typedef struct packed {
      logic        busy;
      logic        done;
      logic [11:0] cluster_count;
      logic        any_percolates;
      logic [12:0] largest_size;
   } walk_status_type;

   // clamp a written side to the range in use
   function automatic logic [SideW-1:0] clamp_side(input logic [6:0] raw);
      logic [SideW-1:0] r;
      if (raw < 7'd2) r = SideW'(2);
      else if (32'(raw) > MaxSide) r = SideW'(MaxSide);
      else r = SideW'(raw);
      return r;
   endfunction
endpackage

// File: sv/gcp_walk.sv
module gcp_walk
   import gcp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SideW-1:0]     side,
   input  logic                 load_we,
   input  addr_type             load_addr,
   input  logic                 load_bit,
   output walk_status_type      status
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLR_RD = 4'd1;
   localparam logic [3:0] S_CLR_WR = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_SCANW  = 4'd4;
   localparam logic [3:0] S_POP    = 4'd5;
   localparam logic [3:0] S_POPW   = 4'd6;
   localparam logic [3:0] S_NB     = 4'd7;
   localparam logic [3:0] S_NBW    = 4'd8;
   localparam logic [3:0] S_END    = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   // site and visited marks packed side by side: bit1 site, bit0 visited
   // sites sit at row * side + col
   logic [1:0]  cell_mem [CellCount];
   // pending sites kept as {row, col}
   addr_type    stack_mem [CellCount];

   logic [3:0]  state_ff, state_in;
   addr_type    scan_ff, scan_in;       // also the clearing pointer
   logic [CoordW-1:0] srow_ff, srow_in, scol_ff, scol_in;
   logic [SpW-1:0] sp_ff, sp_in;
   logic [CoordW-1:0] row_ff, row_in, col_ff, col_in;
   logic [1:0]  nb_ff, nb_in;
   addr_type    nb_rc_ff, nb_rc_in;
   addr_type    nb_addr_ff, nb_addr_in;
   logic [12:0] size_ff, size_in;
   logic [3:0]  edge_ff, edge_in;
   logic [11:0] count_ff, count_in;
   logic        any_ff, any_in;
   logic [12:0] best_ff, best_in;

   logic        cm_we;
   addr_type    cm_waddr;
   logic [1:0]  cm_wdata;
   addr_type    cm_raddr;
   logic [1:0]  cm_rdata_ff;
   logic        st_we;
   addr_type    st_waddr, st_wdata;
   addr_type    st_raddr, st_rdata_ff;

   logic [SideW-1:0] last;
   logic [AddrW:0] cells;
   logic        nb_ok;
   logic [CoordW-1:0] nb_row, nb_col;
   logic [CoordW-1:0] pop_row, pop_col;
   addr_type    nb_addr;

   assign last = side - SideW'(1);
   assign cells = (AddrW+1)'(side) * (AddrW+1)'(side);
   assign pop_row = st_rdata_ff[AddrW-1:CoordW];
   assign pop_col = st_rdata_ff[CoordW-1:0];

   always_ff @(posedge clock) begin
      if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
      cm_rdata_ff <= cell_mem[cm_raddr];
      if (st_we) stack_mem[st_waddr] <= st_wdata;
      st_rdata_ff <= stack_mem[st_raddr];
   end

   // neighbour order: down, up, left, right
   always_comb begin
      nb_ok  = 1'b0;
      nb_row = row_ff;
      nb_col = col_ff;
      case (nb_ff)
         2'd0: begin
            nb_ok  = SideW'(row_ff) != last;
            nb_row = row_ff + CoordW'(1);
         end
         2'd1: begin
            nb_ok  = row_ff != '0;
            nb_row = row_ff - CoordW'(1);
         end
         2'd2: begin
            nb_ok  = col_ff != '0;
            nb_col = col_ff - CoordW'(1);
         end
         default: begin
            nb_ok  = SideW'(col_ff) != last;
            nb_col = col_ff + CoordW'(1);
         end
      endcase
   end

   assign nb_addr = AddrW'(nb_row) * AddrW'(side) + AddrW'(nb_col);

   always_comb begin
      state_in = state_ff; scan_in = scan_ff; sp_in = sp_ff;
      row_in = row_ff; col_in = col_ff; srow_in = srow_ff; scol_in = scol_ff;
      nb_in = nb_ff; nb_rc_in = nb_rc_ff; nb_addr_in = nb_addr_ff;
      size_in = size_ff; edge_in = edge_ff;
      count_in = count_ff; any_in = any_ff; best_in = best_ff;
      cm_we = 1'b0; cm_waddr = load_addr; cm_wdata = {load_bit, 1'b0};
      cm_raddr = scan_ff; st_we = 1'b0; st_waddr = sp_ff[AddrW-1:0];
      st_wdata = nb_rc_ff; st_raddr = sp_ff[AddrW-1:0] - addr_type'(1);
      case (state_ff)
         S_IDLE: begin
            cm_we = load_we;
            if (start) begin
               state_in = S_CLR_RD; scan_in = '0;
               count_in = '0; any_in = 1'b0; best_in = '0;
            end
         end
         S_CLR_RD: begin
            state_in = S_CLR_WR;
         end
         S_CLR_WR: begin
            // keep the site, drop the visited mark
            cm_we = 1'b1; cm_waddr = scan_ff; cm_wdata = {cm_rdata_ff[1], 1'b0};
            if ({1'b0, scan_ff} == cells - (AddrW+1)'(1)) begin
               scan_in = '0; srow_in = '0; scol_in = '0;
               state_in = S_SCAN;
            end else begin
               scan_in = scan_ff + addr_type'(1);
               state_in = S_CLR_RD;
            end
         end
         S_SCAN: begin
            state_in = S_SCANW;
         end
         S_SCANW: begin
            // cm_rdata_ff holds entry scan_ff
            if (cm_rdata_ff[1] && !cm_rdata_ff[0]) begin
               cm_we = 1'b1; cm_waddr = scan_ff; cm_wdata = 2'b11;
               if (count_ff != 12'hFFF) count_in = count_ff + 12'd1;
               st_we = 1'b1; st_waddr = '0; st_wdata = {srow_ff, scol_ff};
               sp_in = SpW'(1); size_in = '0; edge_in = '0;
               state_in = S_POP;
            end else begin
               state_in = S_END;
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               if ((edge_ff[1:0] == 2'b11) || (edge_ff[3:2] == 2'b11)) begin
                  any_in = 1'b1;
                  if (size_ff > best_ff) best_in = size_ff;
               end
               state_in = S_END;
            end else begin
               sp_in = sp_ff - SpW'(1);
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            row_in = pop_row; col_in = pop_col;
            edge_in = edge_ff | {SideW'(pop_col) == last, pop_col == '0,
                                 SideW'(pop_row) == last, pop_row == '0};
            if (size_ff != 13'h1FFF) size_in = size_ff + 13'd1;
            nb_in = 2'd0;
            state_in = S_NB;
         end
         S_NB: begin
            if (nb_ok) begin
               cm_raddr = nb_addr; nb_addr_in = nb_addr;
               nb_rc_in = {nb_row, nb_col};
               state_in = S_NBW;
            end else if (nb_ff == 2'd3) begin
               state_in = S_POP;
            end else begin
               nb_in = nb_ff + 2'd1;
            end
         end
         S_NBW: begin
            if (cm_rdata_ff[1] && !cm_rdata_ff[0]) begin
               cm_we = 1'b1; cm_waddr = nb_addr_ff; cm_wdata = 2'b11;
               st_we = 1'b1; st_waddr = sp_ff[AddrW-1:0]; st_wdata = nb_rc_ff;
               sp_in = sp_ff + SpW'(1);
            end
            if (nb_ff == 2'd3) begin
               state_in = S_POP;
            end else begin
               nb_in = nb_ff + 2'd1;
               state_in = S_NB;
            end
         end
         S_END: begin
            if (SideW'(srow_ff) == last && SideW'(scol_ff) == last) begin
               state_in = S_DONE;
            end else begin
               scan_in = scan_ff + addr_type'(1);
               if (SideW'(scol_ff) == last) begin
                  scol_in = '0; srow_in = srow_ff + CoordW'(1);
               end else begin
                  scol_in = scol_ff + CoordW'(1);
               end
               state_in = S_SCAN;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; sp_ff <= '0; size_ff <= '0; edge_ff <= '0;
         count_ff <= '0; any_ff <= 1'b0; best_ff <= '0;
         scan_ff <= '0; srow_ff <= '0; scol_ff <= '0; row_ff <= '0; col_ff <= '0;
         nb_ff <= '0; nb_rc_ff <= '0; nb_addr_ff <= '0;
      end else begin
         state_ff <= state_in; sp_ff <= sp_in; size_ff <= size_in; edge_ff <= edge_in;
         count_ff <= count_in; any_ff <= any_in; best_ff <= best_in;
         scan_ff <= scan_in; srow_ff <= srow_in; scol_ff <= scol_in;
         row_ff <= row_in; col_ff <= col_in;
         nb_ff <= nb_in; nb_rc_ff <= nb_rc_in; nb_addr_ff <= nb_addr_in;
      end
   end

   assign status.busy = state_ff != S_IDLE;
   assign status.done = state_ff == S_DONE;
   assign status.cluster_count = count_ff;
   assign status.any_percolates = any_ff;
   assign status.largest_size = best_ff;
endmodule

// File: sv/grid_cluster_percolation_core.sv
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_site_occupied, req_last_site
// rsp     | out       | rsp_valid, rsp_stall, rsp_cluster_count, ...
// csr     | in        | csr_valid, csr_ready, csr_grid_side
// Sites load one per cycle, while req is not stalled, into the site memory at row * side + col.
// After the last site the walk clears the visited marks site by site, scans every site,
// and walks each cluster from its first occupied site, marking and stacking its
// neighbours; when the walk ends, the result is registered into the response outputs.
// Reset is synchronous; the site memory itself is not cleared.
// req is stalled from the last site until the result is taken.
module grid_cluster_percolation_core
   import gcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_site_occupied,
   input  logic        req_last_site,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_cluster_count,
   output logic        rsp_any_percolates,
   output logic [12:0] rsp_largest_percolating_size,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_grid_side
);
   logic [6:0]     side_ff;
   logic [AddrW:0] pos_ff;
   logic [AddrW:0] cells;
   logic [SideW-1:0] side;
   logic           accept, start, load, rv_ff;
   walk_status_type st;

   assign side = clamp_side(side_ff);
   assign cells = (AddrW+1)'(side) * (AddrW+1)'(side);
   assign accept = req_valid && !req_stall;
   assign start = accept && req_last_site;
   // drop sites past the end of the grid
   assign load = accept && (pos_ff < cells);
   assign req_stall = st.busy || rv_ff;
   assign csr_ready = 1'b1;

   gcp_walk u_walk (
      .clock(clock), .reset(reset), .start(start), .side(side),
      .load_we(load), .load_addr(pos_ff[AddrW-1:0]),
      .load_bit(req_site_occupied), .status(st)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SideReset; pos_ff <= '0; rv_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) side_ff <= csr_grid_side;
         if (start) begin
            pos_ff <= '0;
         end else if (load) begin
            pos_ff <= pos_ff + (AddrW+1)'(1);
         end
         if (st.done) rv_ff <= 1'b1;
         else if (!rsp_stall) rv_ff <= 1'b0;
      end
      if (st.done) begin
         rsp_cluster_count <= st.cluster_count;
         rsp_any_percolates <= st.any_percolates;
         rsp_largest_percolating_size <= st.largest_size;
      end
   end
   assign rsp_valid = rv_ff;
endmodule

// File: sv/gcp_checker.sv
`include "grid_cluster_percolation_core_macros.svh"
module gcp_checker
   import gcp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_any_percolates,
   input logic [12:0] rsp_largest_percolating_size,
   input logic [11:0] rsp_cluster_count
);
   `GCP_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "result dropped")
   `GCP_ASSERT(a_no_percolate_size, rsp_valid && !rsp_any_percolates |-> rsp_largest_percolating_size == '0, "size without percolation")
   `GCP_ASSERT(a_stall_while_rsp, rsp_valid |-> req_stall, "input taken while result waits")
   `GCP_ASSERT(a_perc_has_cluster, rsp_valid && rsp_any_percolates |-> rsp_cluster_count != '0, "percolation without cluster")
endmodule

bind grid_cluster_percolation_core gcp_checker u_gcp_checker (.*);

// File: bench/grid_cluster_percolation_core_tb.sv
module grid_cluster_percolation_core_tb;
   import gcp_pkg::*;

   localparam int WatchLimit = 200000;

   typedef struct {
      logic [11:0] clusters;
      logic        percolates;
      logic [12:0] biggest;
   } cluster_report_type;

   typedef struct {
      int          side_write;   // -1: keep current side
      int          len;
      logic [15:0] pattern;      // bit i is site i
      bit          typed;
      logic [11:0] clusters;
      logic        percolates;
      logic [12:0] biggest;
   } grid_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_site_occupied = 1'b0;
   logic        req_last_site = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_cluster_count;
   logic        rsp_any_percolates;
   logic [12:0] rsp_largest_percolating_size;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_grid_side = 7'd0;

   grid_cluster_percolation_core dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   bit          site_mem [CellCount];
   bit          site_written [CellCount];
   bit          walk_seen [CellCount];
   int          walk_stack [CellCount];
   int          load_pos;
   logic [6:0]  side_reg;
   cluster_report_type expected_reports [$];

   int  sender_idle_pct;
   int  receiver_stall_pct;
   int  failures;
   int  quiet_cycles;
   int  items_sent;

   function automatic int side_now();
      if (side_reg < 7'd2) return 2;
      if (int'(side_reg) > MaxSide) return MaxSide;
      return int'(side_reg);
   endfunction

   function automatic cluster_report_type label_clusters();
      cluster_report_type rep;
      int side, cells, count, best, sp, p, r, c, sz;
      bit any;
      logic [3:0] edges;
      side = side_now();
      cells = side * side;
      count = 0;
      best = 0;
      any = 0;
      for (int k = 0; k < CellCount; k++) walk_seen[k] = 0;
      for (int i = 0; i < cells; i++) begin
         if (!site_mem[i] || walk_seen[i]) continue;
         count++;
         sz = 0;
         edges = '0;
         sp = 1;
         walk_stack[0] = i;
         walk_seen[i] = 1;
         while (sp > 0) begin
            sp--;
            p = walk_stack[sp];
            r = p / side;
            c = p % side;
            sz++;
            if (r == 0) edges[0] = 1;
            if (r == side - 1) edges[1] = 1;
            if (c == 0) edges[2] = 1;
            if (c == side - 1) edges[3] = 1;
            for (int d = 0; d < 4; d++) begin
               int q;
               bit ok;
               case (d)
                  0: begin ok = (r + 1 < side); q = p + side; end
                  1: begin ok = (r > 0); q = p - side; end
                  2: begin ok = (c > 0); q = p - 1; end
                  default: begin ok = (c + 1 < side); q = p + 1; end
               endcase
               if (ok && site_mem[q] && !walk_seen[q]) begin
                  walk_seen[q] = 1;
                  walk_stack[sp] = q;
                  sp++;
               end
            end
         end
         if (edges[1:0] == 2'b11 || edges[3:2] == 2'b11) begin
            any = 1;
            if (sz > best) best = sz;
         end
      end
      rep.clusters = (count > 4095) ? 12'd4095 : 12'(count);
      rep.percolates = any;
      rep.biggest = (best > 8191) ? 13'd8191 : 13'(best);
      return rep;
   endfunction

   // returns 1 when the transaction closed a grid
   function automatic bit take_site(bit occ, bit last);
      int cells;
      cells = side_now() * side_now();
      if (load_pos < cells) begin
         site_mem[load_pos] = occ;
         site_written[load_pos] = 1;
         load_pos++;
      end
      if (last) load_pos = 0;
      return last;
   endfunction

   // shortest grid that reads no never-written site
   function automatic int shortest_grid();
      int cells, m;
      cells = side_now() * side_now();
      m = 1;
      for (int k = 0; k < cells; k++)
         if (!site_written[k]) m = k + 1;
      return m;
   endfunction

   task automatic send_site(bit occ, bit last, bit typed, cluster_report_type typed_rep);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_site_occupied <= occ;
      req_last_site <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (take_site(occ, last)) begin
         cluster_report_type rep;
         rep = label_clusters();
         expected_reports.insert(expected_reports.size(), typed ? typed_rep : rep);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_side(logic [6:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_grid_side <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      side_reg = v;
   endtask

   task automatic send_random_grid(int len, int density);
      cluster_report_type none;
      for (int k = 0; k < len; k++)
         send_site($urandom_range(99) < density, k == len - 1, 0, none);
   endtask

   // response side: random stall, check each transaction against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected result: cluster_count %0d", rsp_cluster_count);
               failures++;
            end else begin
               cluster_report_type e;
               e = expected_reports.pop_front();
               if (rsp_cluster_count !== e.clusters) begin
                  $error("cluster_count expected %0d actual %0d", e.clusters, rsp_cluster_count);
                  failures++;
               end
               if (rsp_any_percolates !== e.percolates) begin
                  $error("any_percolates expected %0d actual %0d", e.percolates,
                         rsp_any_percolates);
                  failures++;
               end
               if (rsp_largest_percolating_size !== e.biggest) begin
                  $error("largest_percolating_size expected %0d actual %0d", e.biggest,
                         rsp_largest_percolating_size);
                  failures++;
               end
            end
         end
      end
   end

   // watchdog: count cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WatchLimit) begin
            $display("grid_cluster_percolation_core regression: fail");
            $finish;
         end
      end
   end

   grid_row_type grid_rows [8] = '{
      '{2,   4, 16'h0000, 1, 12'd0, 1'b0, 13'd0},
      '{-1,  4, 16'h000F, 1, 12'd1, 1'b1, 13'd4},
      '{-1,  4, 16'h0009, 1, 12'd2, 1'b0, 13'd0},
      '{-1,  1, 16'h0001, 0, 12'd0, 1'b0, 13'd0},
      '{-1,  7, 16'h0055, 0, 12'd0, 1'b0, 13'd0},
      '{0,   4, 16'h0006, 1, 12'd2, 1'b0, 13'd0},
      '{1,   4, 16'h000A, 0, 12'd0, 1'b0, 13'd0},
      '{3,   9, 16'h01FF, 1, 12'd1, 1'b1, 13'd9}
   };

   initial begin
      cluster_report_type typed_rep;
      int side, cells, len, min_len, pick;
      failures = 0;
      items_sent = 0;
      quiet_cycles = 0;
      load_pos = 0;
      side_reg = SideReset;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      for (int k = 0; k < CellCount; k++) begin
         site_mem[k] = 0;
         site_written[k] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (grid_rows[g]) begin
         if (grid_rows[g].side_write >= 0) write_side(7'(grid_rows[g].side_write));
         typed_rep.clusters = grid_rows[g].clusters;
         typed_rep.percolates = grid_rows[g].percolates;
         typed_rep.biggest = grid_rows[g].biggest;
         for (int k = 0; k < grid_rows[g].len; k++)
            send_site(grid_rows[g].pattern[k], k == grid_rows[g].len - 1,
                      grid_rows[g].typed, typed_rep);
      end

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
            default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
         endcase
         while (items_sent < 40 + 450 * (ph + 1)) begin
            pick = $urandom_range(99);
            if (pick < 8) write_side(7'($urandom_range(1)));
            else if (pick < 25) write_side(7'($urandom_range(2, 8)));
            else if (pick < 29) write_side(7'($urandom_range(9, 16)));
            else if (pick < 33) wait_drained();
            side = side_now();
            cells = side * side;
            min_len = shortest_grid();
            pick = $urandom_range(99);
            if (pick < 75 || min_len >= cells) len = cells;
            else if (pick < 88) len = $urandom_range(min_len, cells - 1);
            else len = cells + $urandom_range(1, 5);
            if (len < min_len) len = cells;
            case ($urandom_range(4))
               0: send_random_grid(len, 0);
               1: send_random_grid(len, 30);
               2: send_random_grid(len, 60);
               3: send_random_grid(len, 80);
               default: send_random_grid(len, 100);
            endcase
         end
      end

      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (failures == 0) begin
         $display("grid_cluster_percolation_core regression: pass");
      end else begin
         $display("grid_cluster_percolation_core regression: fail");
      end
      $finish;
   end
endmodule
